@@ sv/kpsc_pkg.sv @@
package kpsc_pkg;

  localparam int unsigned ROWS = 4;

  // command bytes: set / clear one bit of the output latch
  localparam logic [7:0] CMD_SET0 = 8'd97;
  localparam logic [7:0] CMD_CLR0 = 8'd98;
  localparam logic [7:0] CMD_SET1 = 8'd99;
  localparam logic [7:0] CMD_CLR1 = 8'd100;
  localparam logic [7:0] CMD_SET2 = 8'd101;
  localparam logic [7:0] CMD_CLR2 = 8'd102;

  typedef struct packed {
    logic [1:0] column;
    logic       awaiting;
    logic [1:0] held_row;
    logic [2:0] latch;
  } kpsc_state_t;

  typedef struct packed {
    logic       key_valid;
    logic [4:0] key_code;
    logic [1:0] column_drive;
    logic [2:0] output_bits;
  } kpsc_result_t;

  function automatic logic [4:0] key_lookup(input logic [1:0] col, input logic [1:0] row);
    logic [4:0] code;
    case ({col, row})
      4'h0: code = 5'd1;
      4'h1: code = 5'd4;
      4'h2: code = 5'd7;
      4'h3: code = 5'd11;
      4'h4: code = 5'd2;
      4'h5: code = 5'd5;
      4'h6: code = 5'd8;
      4'h7: code = 5'd10;
      4'h8: code = 5'd3;
      4'h9: code = 5'd6;
      4'hA: code = 5'd9;
      4'hB: code = 5'd12;
      4'hC: code = 5'd13;
      4'hD: code = 5'd14;
      4'hE: code = 5'd15;
      default: code = 5'd16;
    endcase
    return code;
  endfunction

endpackage

@@ sv/kpsc_if.sv @@
interface kpsc_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] row_sense;
  logic [7:0] command_byte;

  modport source (output valid, output cmd, output row_sense, output command_byte,
                  input ready);
  modport sink (input valid, input cmd, input row_sense, input command_byte,
                output ready);
endinterface

interface kpsc_result_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [4:0] key_code;
  logic [1:0] column_drive;
  logic [2:0] output_bits;

  modport source (output valid, output key_valid, output key_code, output column_drive,
                  output output_bits, input ready);
  modport sink (input valid, input key_valid, input key_code, input column_drive,
                input output_bits, output ready);
endinterface

@@ sv/keypad_scanner_with_output_commands_core.sv @@
// 4x4 keypad scanner with command-driven output bits. Each item on the item
// channel is either a scan tick (cmd = 0) carrying the active-low row lines of the
// column named by the last column_drive, or a command byte (cmd = 1) that sets or
// clears one of three output bits. Every item produces exactly one result in the
// cycle after its transfer: key_valid/key_code for a new press, the column to drive
// next, and the output latch. One item per cycle is accepted; the only stall comes
// from the single result register when the result channel is not ready.
module keypad_scanner_with_output_commands_core (
  input  logic                 clk,
  input  logic                 rst,
  kpsc_item_if.sink            item,
  kpsc_result_if.source        result
);
  import kpsc_pkg::*;

  kpsc_state_t  state;
  kpsc_state_t  state_next;
  kpsc_result_t step_result;
  kpsc_result_t res;
  logic         res_valid;
  logic         take;

  assign item.ready = !res_valid || result.ready;
  assign take = item.valid && item.ready;

  kpsc_step u_step (
    .state        (state),
    .cmd          (item.cmd),
    .row_sense    (item.row_sense),
    .command_byte (item.command_byte),
    .state_next   (state_next),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= step_result;
    end
  end

  assign result.valid = res_valid;
  assign result.key_valid = res.key_valid;
  assign result.key_code = res.key_code;
  assign result.column_drive = res.column_drive;
  assign result.output_bits = res.output_bits;

endmodule

@@ sv/kpsc_step.sv @@
module kpsc_step (
  input  kpsc_pkg::kpsc_state_t  state,
  input  logic                   cmd,
  input  logic [3:0]             row_sense,
  input  logic [7:0]             command_byte,
  output kpsc_pkg::kpsc_state_t  state_next,
  output kpsc_pkg::kpsc_result_t result
);
  import kpsc_pkg::*;

  logic       pressed;
  logic [1:0] low_row;
  logic [4:0] code;

  // lowest active-low row wins
  always_comb begin
    pressed = 1'b0;
    low_row = 2'd0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_sense[r]) begin
        pressed = 1'b1;
        low_row = 2'(r);
      end
    end
  end

  assign code = key_lookup(state.column, low_row);

  always_comb begin
    state_next = state;
    result.key_valid = 1'b0;
    result.key_code = 5'd0;
    if (cmd) begin
      case (command_byte)
        CMD_SET0: state_next.latch[0] = 1'b1;
        CMD_CLR0: state_next.latch[0] = 1'b0;
        CMD_SET1: state_next.latch[1] = 1'b1;
        CMD_CLR1: state_next.latch[1] = 1'b0;
        CMD_SET2: state_next.latch[2] = 1'b1;
        CMD_CLR2: state_next.latch[2] = 1'b0;
        default: state_next.latch = state.latch;
      endcase
    end else if (state.awaiting) begin
      if (row_sense[state.held_row]) begin
        state_next.awaiting = 1'b0;
        state_next.column = state.column + 2'd1;
      end
    end else if (pressed) begin
      result.key_valid = 1'b1;
      result.key_code = code;
      state_next.held_row = low_row;
      state_next.awaiting = 1'b1;
    end else begin
      state_next.column = state.column + 2'd1;
    end
    result.column_drive = state_next.column;
    result.output_bits = state_next.latch;
  end

endmodule

@@ sv/kpsc_checker.sv @@
module kpsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       key_valid,
  input logic [4:0] key_code,
  input logic [1:0] column_drive,
  input logic [2:0] output_bits
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(key_valid) && $stable(key_code) &&
      $stable(column_drive) && $stable(output_bits))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (key_valid == (key_code != 5'd0)))
    else $error("key_code does not match key_valid");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> key_code <= 5'd16)
    else $error("key_code out of range");

  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind keypad_scanner_with_output_commands_core kpsc_checker u_kpsc_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .key_valid    (result.key_valid),
  .key_code     (result.key_code),
  .column_drive (result.column_drive),
  .output_bits  (result.output_bits)
);
